FILE: src/bsc_pkg.sv
package bsc_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegAc1Ac2 = 3'd0;
  localparam logic [2:0] RegAc3Ac4 = 3'd1;
  localparam logic [2:0] RegAc5Ac6 = 3'd2;
  localparam logic [2:0] RegB1B2   = 3'd3;
  localparam logic [2:0] RegMcMd   = 3'd4;
  localparam logic [2:0] RegOss    = 3'd5;

  localparam logic [31:0] B6Offset  = 32'd4000;
  localparam logic [31:0] CoefA     = 32'd3038;
  localparam logic [31:0] CoefB     = 32'd7357;
  localparam logic [31:0] CoefC     = 32'd3791;
  localparam logic [31:0] B7Scale   = 32'd50000;
  localparam logic [31:0] B4Bias    = 32'd32768;
  localparam logic [31:0] SignBit   = 32'h8000_0000;

  // 16-bit half, sign extended to 32 bits
  function automatic logic [31:0] sext16(input logic [15:0] h);
    sext16 = {{16{h[15]}}, h};
  endfunction

  // Arithmetic right shift of a 32-bit word
  function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] n);
    sra = 32'($signed(x) >>> n);
  endfunction

endpackage

FILE: src/barometric_sensor_compensation.sv
// An accepted input request passes through two 33-stage dividers plus 12 arithmetic
// stages to its result. Throughput: one request per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (async, active low) clears all valid bits and all configuration
// registers to zero; payload registers are not reset.
module barometric_sensor_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] raw_temperature_i,
  input  logic [23:0] raw_pressure_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] temperature_deci_c_o,
  output logic [31:0] pressure_pa_o,
  output logic        status_o
);

  localparam int PwA = 58;
  localparam int PwB = 34;

  // Configuration registers
  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac12_q <= '0; ac34_q <= '0; ac56_q <= '0; b12_q <= '0; mcmd_q <= '0; oss_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bsc_pkg::RegAc1Ac2: ac12_q <= cfg_data_i;
        bsc_pkg::RegAc3Ac4: ac34_q <= cfg_data_i;
        bsc_pkg::RegAc5Ac6: ac56_q <= cfg_data_i;
        bsc_pkg::RegB1B2:   b12_q  <= cfg_data_i;
        bsc_pkg::RegMcMd:   mcmd_q <= cfg_data_i;
        bsc_pkg::RegOss:    oss_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bsc_pkg::sext16(ac12_q[31:16]);
  assign ac2 = bsc_pkg::sext16(ac12_q[15:0]);
  assign ac3 = bsc_pkg::sext16(ac34_q[31:16]);
  assign ac4 = {16'd0, ac34_q[15:0]};
  assign ac5 = {16'd0, ac56_q[31:16]};
  assign ac6 = {16'd0, ac56_q[15:0]};
  assign b1  = bsc_pkg::sext16(b12_q[31:16]);
  assign b2  = bsc_pkg::sext16(b12_q[15:0]);
  assign mc  = bsc_pkg::sext16(mcmd_q[31:16]);
  assign md  = bsc_pkg::sext16(mcmd_q[15:0]);

  // Whole pipeline advances unless the output holds a stalled result
  logic adv;
  logic out_vld_q;
  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 1: x1 = ((ut - ac6) * ac5) >>> 15
  logic        v1_q;
  logic [31:0] x1_1_q;
  logic [23:0] up1_q;
  logic [31:0] s1_prod;
  assign s1_prod = ({16'd0, raw_temperature_i} - ac6) * ac5;

  // Stage 2: divisor check and operand magnitudes
  logic        v2_q;
  logic [31:0] x1_2_q, na2_q, da2_q;
  logic [23:0] up2_q;
  logic        neg2_q, fail2_q;
  logic [31:0] s2_div, s2_num;
  assign s2_div = x1_1_q + md;
  assign s2_num = mc << 11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i; v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_1_q  <= bsc_pkg::sra(s1_prod, 5'd15);
      up1_q   <= raw_pressure_i;
      x1_2_q  <= x1_1_q;
      up2_q   <= up1_q;
      na2_q   <= s2_num[31] ? (32'd0 - s2_num) : s2_num;
      da2_q   <= s2_div[31] ? (32'd0 - s2_div) : s2_div;
      neg2_q  <= s2_num[31] ^ s2_div[31];
      fail2_q <= (s2_div == 32'd0);
    end
  end

  // Temperature division: x2 = (mc << 11) / (x1 + md)
  logic           va_o;
  logic [31:0]    qa;
  logic [PwA-1:0] pla;
  logic [31:0]    x1_a;
  logic [23:0]    up_a;
  logic           fail_a, neg_a;

  bsc_div_pipe #(.W(32), .PW(PwA)) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .num_i   (na2_q),
    .den_i   (da2_q),
    .pl_i    ({x1_2_q, up2_q, fail2_q, neg2_q}),
    .valid_o (va_o),
    .quo_o   (qa),
    .pl_o    (pla)
  );
  assign {x1_a, up_a, fail_a, neg_a} = pla;

  // Stage 3: b5, t, b6 and shifted pressure
  logic [31:0] s3_b5, s3_v, s3_t;
  assign s3_b5 = x1_a + (neg_a ? (32'd0 - qa) : qa);
  assign s3_v  = s3_b5 + 32'd8;
  assign s3_t  = bsc_pkg::sra(s3_v + (s3_v[31] ? 32'd15 : 32'd0), 5'd4);

  logic        v3_q, fail3_q;
  logic [31:0] t3_q, b6_3_q, up3_q;

  // Stage 4: products of b6
  logic        v4_q, fail4_q;
  logic [31:0] t4_q, up4_q, sq4_q, x2a4_q, x1c4_q;
  logic [31:0] s4_sq, s4_a2, s4_a3;
  assign s4_sq = b6_3_q * b6_3_q;
  assign s4_a2 = ac2 * b6_3_q;
  assign s4_a3 = ac3 * b6_3_q;

  // Stage 5: products of sq
  logic        v5_q, fail5_q;
  logic [31:0] t5_q, up5_q, x2a5_q, x1c5_q, x1b5_q, x2c5_q;
  logic [31:0] s5_b2, s5_b1;
  assign s5_b2 = b2 * sq4_q;
  assign s5_b1 = b1 * sq4_q;

  // Stage 6: b3 and x3
  logic        v6_q, fail6_q;
  logic [31:0] t6_q, up6_q, b3_6_q, x3_6_q;
  logic [31:0] s6_tmp;
  assign s6_tmp = ((ac1 << 2) + x1b5_q + x2a5_q) << oss_q;

  // Stage 7: b4 and up - b3
  logic        v7_q, fail7_q;
  logic [31:0] t7_q, b4_7_q, d7_q;
  logic [31:0] s7_prod;
  assign s7_prod = ac4 * (x3_6_q + bsc_pkg::B4Bias);

  // Stage 8: b7
  logic        v8_q, fail8_q;
  logic [31:0] t8_q, b4_8_q, b7_8_q;
  logic [31:0] s8_scale;
  assign s8_scale = bsc_pkg::B7Scale >> oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
    end else if (adv) begin
      v3_q <= va_o; v4_q <= v3_q; v5_q <= v4_q;
      v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fail3_q <= fail_a;
      t3_q    <= s3_t;
      b6_3_q  <= s3_b5 - bsc_pkg::B6Offset;
      up3_q   <= {8'd0, up_a} >> (4'd8 - {2'd0, oss_q});

      fail4_q <= fail3_q; t4_q <= t3_q; up4_q <= up3_q;
      sq4_q   <= bsc_pkg::sra(s4_sq, 5'd12);
      x2a4_q  <= bsc_pkg::sra(s4_a2, 5'd11);
      x1c4_q  <= bsc_pkg::sra(s4_a3, 5'd13);

      fail5_q <= fail4_q; t5_q <= t4_q; up5_q <= up4_q;
      x2a5_q  <= x2a4_q; x1c5_q <= x1c4_q;
      x1b5_q  <= bsc_pkg::sra(s5_b2, 5'd11);
      x2c5_q  <= bsc_pkg::sra(s5_b1, 5'd16);

      fail6_q <= fail5_q; t6_q <= t5_q; up6_q <= up5_q;
      b3_6_q  <= bsc_pkg::sra(s6_tmp + 32'd2, 5'd2);
      x3_6_q  <= bsc_pkg::sra(x1c5_q + x2c5_q + 32'd2, 5'd2);

      fail7_q <= fail6_q; t7_q <= t6_q;
      b4_7_q  <= s7_prod >> 15;
      d7_q    <= up6_q - b3_6_q;

      fail8_q <= fail7_q | (b4_7_q == 32'd0);
      t8_q    <= t7_q; b4_8_q <= b4_7_q;
      b7_8_q  <= d7_q * s8_scale;
    end
  end

  // Pressure division: p = (b7 << 1) / b4, or (b7 / b4) << 1 for large b7
  logic           big8;
  logic           vb_o;
  logic [31:0]    qb;
  logic [PwB-1:0] plb;
  logic [31:0]    t_b;
  logic           fail_b, big_b;
  assign big8 = (b7_8_q >= bsc_pkg::SignBit);

  bsc_div_pipe #(.W(32), .PW(PwB)) u_div_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v8_q),
    .num_i   (big8 ? b7_8_q : (b7_8_q << 1)),
    .den_i   (b4_8_q),
    .pl_i    ({t8_q, fail8_q, big8}),
    .valid_o (vb_o),
    .quo_o   (qb),
    .pl_o    (plb)
  );
  assign {t_b, fail_b, big_b} = plb;

  // Stage 9: p
  logic        v9_q, fail9_q;
  logic [31:0] t9_q, p9_q;

  // Stage 10: squares and linear term
  logic        v10_q, fail10_q;
  logic [31:0] t10_q, p10_q, sqp10_q, x2_10_q;
  logic [31:0] s10_a, s10_m;
  assign s10_a = bsc_pkg::sra(p9_q, 5'd8);
  assign s10_m = bsc_pkg::CoefB * p9_q;

  // Stage 11: x1 scaling
  logic        v11_q, fail11_q;
  logic [31:0] t11_q, p11_q, x1_11_q, x2_11_q;
  logic [31:0] s11_m;
  assign s11_m = sqp10_q * bsc_pkg::CoefA;

  // Output register
  logic [31:0] s12_pres;
  logic [31:0] temp_q, pres_q;
  logic        stat_q;
  assign s12_pres = p11_q + bsc_pkg::sra(x1_11_q + x2_11_q + bsc_pkg::CoefC, 5'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0; out_vld_q <= 1'b0;
    end else if (adv) begin
      v9_q <= vb_o; v10_q <= v9_q; v11_q <= v10_q; out_vld_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fail9_q  <= fail_b; t9_q <= t_b;
      p9_q     <= big_b ? (qb << 1) : qb;

      fail10_q <= fail9_q; t10_q <= t9_q; p10_q <= p9_q;
      sqp10_q  <= s10_a * s10_a;
      x2_10_q  <= bsc_pkg::sra(32'd0 - s10_m, 5'd16);

      fail11_q <= fail10_q; t11_q <= t10_q; p11_q <= p10_q; x2_11_q <= x2_10_q;
      x1_11_q  <= bsc_pkg::sra(s11_m, 5'd16);

      temp_q   <= fail11_q ? 32'd0 : t11_q;
      pres_q   <= fail11_q ? 32'd0 : s12_pres;
      stat_q   <= fail11_q;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign temperature_deci_c_o = temp_q;
  assign pressure_pa_o        = pres_q;
  assign status_o             = stat_q;

endmodule

FILE: src/bsc_div_pipe.sv
// Unsigned divider, one quotient bit per stage, with side payload
module bsc_div_pipe #(
  parameter int W  = 32,
  parameter int PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [PW-1:0] pl_i,
  output logic          valid_o,
  output logic [W-1:0]  quo_o,
  output logic [PW-1:0] pl_o
);

  logic [W-1:0]  rem_q [W+1];
  logic [W-1:0]  num_q [W+1];
  logic [W-1:0]  den_q [W+1];
  logic [PW-1:0] pl_q  [W+1];
  logic          vld_q [W+1];

  // Load stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      num_q[0] <= num_i;
      den_q[0] <= den_i;
      pl_q[0]  <= pl_i;
    end
  end

  // Restoring division steps
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0] shl;
    logic       ge;
    logic [W:0] dif;
    assign shl = {rem_q[k], num_q[k][W-1]};
    assign dif = shl - {1'b0, den_q[k]};
    assign ge  = (shl >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? dif[W-1:0] : shl[W-1:0];
        num_q[k+1] <= {num_q[k][W-2:0], ge};
        den_q[k+1] <= den_q[k];
        pl_q[k+1]  <= pl_q[k];
      end
    end
  end

  assign valid_o = vld_q[W];
  assign quo_o   = num_q[W];
  assign pl_o    = pl_q[W];

endmodule
